// ----- rtl/pcr_pkg.sv -----
// Shared constants, register map and types of the particle collision resolver.
`timescale 1ns / 1ps
package pcr_pkg;

   // Default coordinate width of the particle ports
   localparam int COORD_WIDTH_DEF = 16;

   // Register reset values
   localparam logic [13:0] WALL_BOUND_RST = 14'd7680;

   // Fixed point constants
   localparam int FRAC_POS = 14;

   // Square root unit: 28 bit radicand, 14 bit root, one root bit per stage
   localparam int RAD_W     = 28;
   localparam int ROOT_W    = 14;
   localparam int SQ_STAGES = ROOT_W;

   // Divider unit: 29 bit dividend, 15 bit divisor and quotient, one bit per stage
   localparam int NUM_W     = 29;
   localparam int QUO_W     = 15;
   localparam int DV_STAGES = QUO_W;

   // Register index on the configuration port
   typedef enum logic [2:0] {
      REG_WALL_BOUND   = 3'd0,
      REG_OBST_MODE    = 3'd1,
      REG_CONTACT_DIST = 3'd2,
      REG_OBST_CENTER  = 3'd3,
      REG_OBST_VEL     = 3'd4
   } reg_idx_type;

   // Obstacle mode codes
   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_SPHERE = 2'd1,
      MODE_CUBE   = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

endpackage

// ----- rtl/pcr_sqrt.sv -----
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module pcr_sqrt
   import pcr_pkg::*;
(
   input  logic              clock,
   input  logic              en,
   input  logic [RAD_W-1:0]  rad,
   output logic [ROOT_W-1:0] root
);

   logic [ROOT_W+1:0] rem_ff  [SQ_STAGES];
   logic [ROOT_W-1:0] root_ff [SQ_STAGES];
   logic [RAD_W-1:0]  rad_ff  [SQ_STAGES];
   logic [ROOT_W+1:0] rem_in  [SQ_STAGES];
   logic [ROOT_W-1:0] root_in [SQ_STAGES];
   logic [RAD_W-1:0]  rad_in  [SQ_STAGES];

   // Bring down two radicand bits and try the next root bit
   always_comb begin
      logic [ROOT_W+3:0] cur;
      logic [ROOT_W+3:0] trial;
      logic [ROOT_W+1:0] prem;
      logic [ROOT_W-1:0] proot;
      logic [RAD_W-1:0]  prad;
      for (int k = 0; k < SQ_STAGES; k++) begin
         if (k == 0) begin
            prem  = '0;
            proot = '0;
            prad  = rad;
         end else begin
            prem  = rem_ff[k-1];
            proot = root_ff[k-1];
            prad  = rad_ff[k-1];
         end
         cur   = {prem, prad[RAD_W-1 -: 2]};
         trial = {2'b00, proot, 2'b01};
         rad_in[k] = {prad[RAD_W-3:0], 2'b00};
         if (cur >= trial) begin
            rem_in[k]  = (ROOT_W+2)'(cur - trial);
            root_in[k] = {proot[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in[k]  = (ROOT_W+2)'(cur);
            root_in[k] = {proot[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < SQ_STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
            rad_ff[k]  <= rad_in[k];
         end
      end
   end

   assign root = root_ff[SQ_STAGES-1];

endmodule

// ----- rtl/pcr_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module pcr_div
   import pcr_pkg::*;
(
   input  logic             clock,
   input  logic             en,
   input  logic [NUM_W-1:0] num,
   input  logic [QUO_W-1:0] den,
   output logic [QUO_W-1:0] quo
);

   logic [NUM_W-1:0] rem_ff [DV_STAGES];
   logic [QUO_W-1:0] den_ff [DV_STAGES];
   logic [QUO_W-1:0] quo_ff [DV_STAGES];
   logic [NUM_W-1:0] rem_in [DV_STAGES];
   logic [QUO_W-1:0] quo_in [DV_STAGES];
   logic [QUO_W-1:0] den_in [DV_STAGES];

   // Subtract the shifted divisor where it fits, highest quotient bit first
   always_comb begin
      logic [NUM_W-1:0] prem;
      logic [QUO_W-1:0] pden;
      logic [QUO_W-1:0] pquo;
      logic [NUM_W-1:0] trial;
      for (int k = 0; k < DV_STAGES; k++) begin
         if (k == 0) begin
            prem = num;
            pden = den;
            pquo = '0;
         end else begin
            prem = rem_ff[k-1];
            pden = den_ff[k-1];
            pquo = quo_ff[k-1];
         end
         trial     = NUM_W'(pden) << (DV_STAGES - 1 - k);
         den_in[k] = pden;
         if (prem >= trial) begin
            rem_in[k] = prem - trial;
            quo_in[k] = {pquo[QUO_W-2:0], 1'b1};
         end else begin
            rem_in[k] = prem;
            quo_in[k] = {pquo[QUO_W-2:0], 1'b0};
         end
      end
   end

   // Advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < DV_STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

   assign quo = quo_ff[DV_STAGES-1];

endmodule

// ----- rtl/particle_collision_resolve.sv -----
// Throughput: one word per cycle; the square root (14 stages) and the three
// dividers (15 stages) are fully pipelined, one result bit per stage.
// A held result word stalls the whole pipeline; nothing is dropped.
// Reset: synchronous, clears all valid bits and loads register reset values.
`timescale 1ns / 1ps
module particle_collision_resolve
   import pcr_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [5:0]                    paddr,
   input  logic [63:0]                   pwdata,
   output logic [63:0]                   prdata,
   output logic                          pready,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_pos_x,
   input  logic signed [COORD_WIDTH-1:0] req_pos_y,
   input  logic signed [COORD_WIDTH-1:0] req_pos_z,
   input  logic signed [COORD_WIDTH-1:0] req_vel_x,
   input  logic signed [COORD_WIDTH-1:0] req_vel_y,
   input  logic signed [COORD_WIDTH-1:0] req_vel_z,
   input  logic                          req_last_particle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_new_pos_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_pos_y,
   output logic signed [COORD_WIDTH-1:0] rsp_new_pos_z,
   output logic signed [COORD_WIDTH-1:0] rsp_new_vel_x,
   output logic signed [COORD_WIDTH-1:0] rsp_new_vel_y,
   output logic signed [COORD_WIDTH-1:0] rsp_new_vel_z,
   output logic                          rsp_last_out
);

   localparam int VW   = (COORD_WIDTH > 16) ? COORD_WIDTH : 16;
   localparam int RW   = VW + 1;
   localparam int PV_W = RW + 16;
   localparam int VN_W = PV_W + 2;
   localparam int CW   = VN_W + 16;
   localparam int PW   = 18;
   localparam int DLY  = SQ_STAGES + 1 + DV_STAGES;

   localparam logic signed [CW-1:0] SAT_HI = {{(CW-COORD_WIDTH+1){1'b0}},
                                              {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_LO = {{(CW-COORD_WIDTH+1){1'b1}},
                                              {(COORD_WIDTH-1){1'b0}}};

   typedef struct {
      logic                 last;
      logic                 contact;
      logic                 zero;
      logic signed [PW-1:0] p   [3];
      logic signed [VW-1:0] v   [3];
      logic signed [RW-1:0] rel [3];
      logic                 dneg [3];
      logic [13:0]          dmag [3];
   } carry_type;

   function automatic logic signed [COORD_WIDTH-1:0] sat_w(input logic signed [CW-1:0] x);
      if (x > SAT_HI) begin
         return SAT_HI[COORD_WIDTH-1:0];
      end else if (x < SAT_LO) begin
         return SAT_LO[COORD_WIDTH-1:0];
      end
      return x[COORD_WIDTH-1:0];
   endfunction

   // ---------------- configuration registers ----------------
   logic [13:0] wall_bound_ff;
   logic [1:0]  obst_mode_ff;
   logic [13:0] contact_dist_ff;
   logic [47:0] obst_center_ff;
   logic [47:0] obst_vel_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   // Write the addressed register, drop writes beyond the map
   always_ff @(posedge clock) begin
      if (reset) begin
         wall_bound_ff   <= WALL_BOUND_RST;
         obst_mode_ff    <= MODE_NONE;
         contact_dist_ff <= '0;
         obst_center_ff  <= '0;
         obst_vel_ff     <= '0;
      end else if (csr_wr) begin
         unique case (paddr[5:3])
            REG_WALL_BOUND:   wall_bound_ff   <= pwdata[13:0];
            REG_OBST_MODE:    obst_mode_ff    <= pwdata[1:0];
            REG_CONTACT_DIST: contact_dist_ff <= pwdata[13:0];
            REG_OBST_CENTER:  obst_center_ff  <= pwdata[47:0];
            REG_OBST_VEL:     obst_vel_ff     <= pwdata[47:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (paddr[5:3])
         REG_WALL_BOUND:   prdata = 64'(wall_bound_ff);
         REG_OBST_MODE:    prdata = 64'(obst_mode_ff);
         REG_CONTACT_DIST: prdata = 64'(contact_dist_ff);
         REG_OBST_CENTER:  prdata = 64'(obst_center_ff);
         REG_OBST_VEL:     prdata = 64'(obst_vel_ff);
         default:          prdata = '0;
      endcase
   end

   logic signed [15:0] cen [3];
   logic signed [15:0] ovl [3];
   logic [14:0]        rad_r;
   assign rad_r = {1'b0, contact_dist_ff};
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cen[i] = obst_center_ff[16*i +: 16];
         ovl[i] = obst_vel_ff[16*i +: 16];
      end
   end

   // ---------------- pipeline control ----------------
   logic en;
   logic rsp_valid_ff;
   assign en        = ~rsp_valid_ff | rsp_ready;
   assign req_ready = en;

   logic va_ff, vb_ff, vc_ff, vd_ff, vf_ff, vg_ff, vh_ff, vi_ff;
   logic vdl_ff [DLY];

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff        <= 1'b0;
         vb_ff        <= 1'b0;
         vc_ff        <= 1'b0;
         vd_ff        <= 1'b0;
         vf_ff        <= 1'b0;
         vg_ff        <= 1'b0;
         vh_ff        <= 1'b0;
         vi_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < DLY; j++) vdl_ff[j] <= 1'b0;
      end else if (en) begin
         va_ff     <= req_valid;
         vb_ff     <= va_ff;
         vc_ff     <= vb_ff;
         vd_ff     <= vc_ff;
         vdl_ff[0] <= vd_ff;
         for (int j = 1; j < DLY; j++) vdl_ff[j] <= vdl_ff[j-1];
         vf_ff        <= vdl_ff[DLY-1];
         vg_ff        <= vf_ff;
         vh_ff        <= vg_ff;
         vi_ff        <= vh_ff;
         rsp_valid_ff <= vi_ff;
      end
   end

   // ---------------- stage A: wall clamp ----------------
   logic signed [COORD_WIDTH-1:0] in_p [3];
   logic signed [COORD_WIDTH-1:0] in_v [3];
   assign in_p[0] = req_pos_x;
   assign in_p[1] = req_pos_y;
   assign in_p[2] = req_pos_z;
   assign in_v[0] = req_vel_x;
   assign in_v[1] = req_vel_y;
   assign in_v[2] = req_vel_z;

   logic signed [15:0]   a_p_ff [3];
   logic signed [VW-1:0] a_v_ff [3];
   logic signed [15:0]   a_p_in [3];
   logic signed [VW-1:0] a_v_in [3];
   logic                 a_last_ff;

   always_comb begin
      logic signed [RW-1:0] pe;
      logic signed [RW-1:0] wb;
      wb = RW'($signed({1'b0, wall_bound_ff}));
      for (int i = 0; i < 3; i++) begin
         pe = RW'(in_p[i]);
         if (pe < -wb) begin
            a_p_in[i] = 16'(-wb);
            a_v_in[i] = '0;
         end else if (pe > wb) begin
            a_p_in[i] = 16'(wb);
            a_v_in[i] = '0;
         end else begin
            a_p_in[i] = 16'(pe);
            a_v_in[i] = VW'(in_v[i]);
         end
      end
   end

   // ---------------- stage B: offsets and relative velocity ----------------
   logic signed [16:0]   b_d_ff   [3];
   logic [16:0]          b_mag_ff [3];
   logic signed [RW-1:0] b_rel_ff [3];
   logic signed [15:0]   b_p_ff   [3];
   logic signed [VW-1:0] b_v_ff   [3];
   logic                 b_last_ff;
   logic signed [16:0]   b_d_in   [3];
   logic [16:0]          b_mag_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         b_d_in[i]   = 17'(a_p_ff[i]) - 17'(cen[i]);
         b_mag_in[i] = b_d_in[i][16] ? 17'(-b_d_in[i]) : 17'(b_d_in[i]);
      end
   end

   // ---------------- stage C: cube response, squares ----------------
   carry_type          c_ff;
   carry_type          c_in;
   logic [27:0]        c_sq_ff [3];
   logic [27:0]        c_r2_ff;
   logic               c_sph_ff;
   logic               c_sph_in;

   always_comb begin
      logic               cube_hit;
      logic [1:0]         ax;
      logic               sg_pos;
      logic [16:0]        r17;
      r17      = {3'b000, contact_dist_ff};
      cube_hit = (obst_mode_ff == MODE_CUBE) && (contact_dist_ff != '0);
      c_sph_in = (obst_mode_ff == MODE_SPHERE) && (contact_dist_ff != '0);
      for (int i = 0; i < 3; i++) begin
         if (b_mag_ff[i] > r17) cube_hit = 1'b0;
         if (b_mag_ff[i] >= r17) c_sph_in = 1'b0;
      end
      // least penetration is the largest offset, ties to the lower axis
      ax = 2'd0;
      if (b_mag_ff[1] > b_mag_ff[0]) ax = 2'd1;
      if (b_mag_ff[2] > b_mag_ff[ax]) ax = 2'd2;
      if (b_d_ff[ax] == '0) sg_pos = ~b_rel_ff[ax][RW-1];
      else sg_pos = ~b_d_ff[ax][16];

      c_in.last    = b_last_ff;
      c_in.contact = 1'b0;
      c_in.zero    = 1'b0;
      for (int i = 0; i < 3; i++) begin
         c_in.p[i]    = PW'(b_p_ff[i]);
         c_in.v[i]    = b_v_ff[i];
         c_in.rel[i]  = b_rel_ff[i];
         c_in.dneg[i] = b_d_ff[i][16];
         c_in.dmag[i] = b_mag_ff[i][13:0];
         // push out along the chosen axis, drop inward relative speed
         if (cube_hit && (ax == 2'(i))) begin
            if (sg_pos) begin
               c_in.p[i] = PW'(cen[i]) + PW'($signed(rad_r));
               if (b_rel_ff[i] < 0) c_in.v[i] = VW'(ovl[i]);
            end else begin
               c_in.p[i] = PW'(cen[i]) - PW'($signed(rad_r));
               if (b_rel_ff[i] > 0) c_in.v[i] = VW'(ovl[i]);
            end
         end
      end
   end

   // ---------------- stage D: squared distance, contact test ----------------
   carry_type   d_ff;
   carry_type   d_in;
   logic [27:0] d_rad_ff;
   logic [29:0] d2_sum;

   always_comb begin
      d2_sum       = 30'(c_sq_ff[0]) + 30'(c_sq_ff[1]) + 30'(c_sq_ff[2]);
      d_in         = c_ff;
      d_in.contact = c_sph_ff && (d2_sum < 30'(c_r2_ff));
      d_in.zero    = (d2_sum == '0);
   end

   // ---------------- delay line across sqrt and divide ----------------
   carry_type          dl_ff [DLY];
   logic [ROOT_W-1:0]  root;
   logic [NUM_W-1:0]   e_num_ff [3];
   logic [QUO_W-1:0]   e_den_ff;
   logic [QUO_W-1:0]   quo [3];

   pcr_sqrt u_sqrt (
      .clock (clock),
      .en    (en),
      .rad   (d_rad_ff),
      .root  (root)
   );

   for (genvar g = 0; g < 3; g++) begin : g_div
      pcr_div u_div (
         .clock (clock),
         .en    (en),
         .num   (e_num_ff[g]),
         .den   (e_den_ff),
         .quo   (quo[g])
      );
   end

   // ---------------- stages F..I: normal, products, correction ----------------
   logic signed [15:0]   f_n_ff [3];
   carry_type            f_ff;
   logic signed [PV_W-1:0] g_pv_ff [3];
   logic signed [30:0]   g_pp_ff [3];
   logic signed [15:0]   g_n_ff  [3];
   carry_type            g_ff;
   logic signed [VN_W-1:0] h_vn_ff;
   logic signed [PW-1:0] h_pos_ff [3];
   logic signed [15:0]   h_n_ff  [3];
   carry_type            h_ff;
   logic signed [CW-1:0] i_pc_ff [3];
   logic                 i_neg_ff;
   logic signed [PW-1:0] i_pos_ff [3];
   carry_type            i_ff;

   logic signed [15:0]   f_n_in [3];
   logic signed [VN_W-1:0] h_vn_in;
   logic signed [PW-1:0] h_pos_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dl_ff[DLY-1].zero) begin
            f_n_in[i] = (i == 1) ? 16'sd16384 : 16'sd0;
         end else if (dl_ff[DLY-1].dneg[i]) begin
            f_n_in[i] = -$signed({1'b0, quo[i]});
         end else begin
            f_n_in[i] = $signed({1'b0, quo[i]});
         end
      end
   end

   always_comb begin
      logic [30:0] m;
      logic [16:0] q;
      h_vn_in = VN_W'(g_pv_ff[0]) + VN_W'(g_pv_ff[1]) + VN_W'(g_pv_ff[2]);
      for (int i = 0; i < 3; i++) begin
         m = g_pp_ff[i][30] ? 31'(-g_pp_ff[i]) : 31'(g_pp_ff[i]);
         q = 17'((m + 31'(1 << (FRAC_POS - 1))) >> FRAC_POS);
         h_pos_in[i] = PW'(cen[i]) +
                       (g_pp_ff[i][30] ? -$signed({1'b0, q}) : $signed({1'b0, q}));
      end
   end

   // ---------------- stage J: apply sphere response, saturate ----------------
   logic signed [COORD_WIDTH-1:0] out_p_ff [3];
   logic signed [COORD_WIDTH-1:0] out_v_ff [3];
   logic signed [COORD_WIDTH-1:0] out_p_in [3];
   logic signed [COORD_WIDTH-1:0] out_v_in [3];
   logic                          out_last_ff;

   always_comb begin
      logic [CW-1:0]        m;
      logic [CW-1:0]        q;
      logic signed [CW-1:0] corr;
      for (int i = 0; i < 3; i++) begin
         m    = i_pc_ff[i][CW-1] ? CW'(-i_pc_ff[i]) : CW'(i_pc_ff[i]);
         q    = (m + (CW'(1) << 27)) >> 28;
         corr = i_pc_ff[i][CW-1] ? -$signed(q) : $signed(q);
         if (i_ff.contact) begin
            out_p_in[i] = sat_w(CW'(i_pos_ff[i]));
            out_v_in[i] = sat_w(CW'(i_ff.rel[i]) + CW'(ovl[i]) - (i_neg_ff ? corr : '0));
         end else begin
            out_p_in[i] = sat_w(CW'(i_ff.p[i]));
            out_v_in[i] = sat_w(CW'(i_ff.v[i]));
         end
      end
   end

   // Hold every payload register while the output word waits
   always_ff @(posedge clock) begin
      if (en) begin
         a_last_ff <= req_last_particle;
         b_last_ff <= a_last_ff;
         for (int i = 0; i < 3; i++) begin
            a_p_ff[i]   <= a_p_in[i];
            a_v_ff[i]   <= a_v_in[i];
            b_d_ff[i]   <= b_d_in[i];
            b_mag_ff[i] <= b_mag_in[i];
            b_rel_ff[i] <= RW'(a_v_ff[i]) - RW'(ovl[i]);
            b_p_ff[i]   <= a_p_ff[i];
            b_v_ff[i]   <= a_v_ff[i];
            c_sq_ff[i]  <= b_mag_ff[i][13:0] * b_mag_ff[i][13:0];
         end
         c_ff     <= c_in;
         c_sph_ff <= c_sph_in;
         c_r2_ff  <= contact_dist_ff * contact_dist_ff;
         d_ff     <= d_in;
         d_rad_ff <= d2_sum[27:0];
         dl_ff[0] <= d_ff;
         for (int j = 1; j < DLY; j++) dl_ff[j] <= dl_ff[j-1];
         e_den_ff <= {1'b0, root};
         for (int i = 0; i < 3; i++) begin
            e_num_ff[i] <= {1'b0, dl_ff[SQ_STAGES-1].dmag[i], 14'b0} +
                           NUM_W'(root >> 1);
            f_n_ff[i]   <= f_n_in[i];
            g_pv_ff[i]  <= f_ff.rel[i] * f_n_ff[i];
            g_pp_ff[i]  <= f_n_ff[i] * $signed(rad_r);
            g_n_ff[i]   <= f_n_ff[i];
            h_pos_ff[i] <= h_pos_in[i];
            h_n_ff[i]   <= g_n_ff[i];
            i_pc_ff[i]  <= h_vn_ff * h_n_ff[i];
            i_pos_ff[i] <= h_pos_ff[i];
            out_p_ff[i] <= out_p_in[i];
            out_v_ff[i] <= out_v_in[i];
         end
         f_ff        <= dl_ff[DLY-1];
         g_ff        <= f_ff;
         h_vn_ff     <= h_vn_in;
         h_ff        <= g_ff;
         i_neg_ff    <= h_vn_ff[VN_W-1];
         i_ff        <= h_ff;
         out_last_ff <= i_ff.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_new_pos_x = out_p_ff[0];
   assign rsp_new_pos_y = out_p_ff[1];
   assign rsp_new_pos_z = out_p_ff[2];
   assign rsp_new_vel_x = out_v_ff[0];
   assign rsp_new_vel_y = out_v_ff[1];
   assign rsp_new_vel_z = out_v_ff[2];
   assign rsp_last_out  = out_last_ff;

endmodule
